// ===== design/rgbc_pkg.sv =====
package rgbc_pkg;

    localparam int MAX_WIDTH_DEFAULT = 2048;
    localparam int COEF_BITS_DEFAULT = 8;

    localparam int CH_BITS      = 8;
    localparam int PIX_BITS     = 3 * CH_BITS;
    localparam int FRAME_W_BITS = 12;
    localparam int FRAME_H_BITS = 16;
    localparam int CFG_INDEX_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_LEFT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MID   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_RIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

    localparam logic [FRAME_W_BITS-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [FRAME_H_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;

    typedef logic [PIX_BITS-1:0] pixel_t;
    typedef logic [CH_BITS-1:0]  chan_t;
    typedef logic [1:0]          col_sel_t;

    // Window columns, oldest first.
    localparam col_sel_t COL_OLD = 2'd0;
    localparam col_sel_t COL_MID = 2'd1;
    localparam col_sel_t COL_NEW = 2'd2;

    typedef struct packed {
        logic     do_shift;
        logic     from_mem;
        logic     do_emit;
        logic     use_post;
        logic     top_rep;
        logic     last;
        col_sel_t lc;
        col_sel_t cc;
    } step_ctl_t;

endpackage

// ===== design/rgbc_line_mem.sv =====
module rgbc_line_mem #(
    parameter int DEPTH = rgbc_pkg::MAX_WIDTH_DEFAULT,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  rgbc_pkg::pixel_t wr_data,
    output rgbc_pkg::pixel_t rd_data
);
    import rgbc_pkg::*;

    pixel_t store_mem [DEPTH];
    pixel_t rd_q_reg;
    pixel_t byp_q_reg;
    logic   byp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // A write to the address being read in the same cycle is forwarded.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg  <= store_mem[rd_addr];
            byp_reg   <= wr_en && (wr_addr == rd_addr);
            byp_q_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_q_reg : rd_q_reg;

endmodule

// ===== design/rgbc_ctrl.sv =====
module rgbc_ctrl #(
    parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEFAULT,
    parameter int COEF_BITS = rgbc_pkg::COEF_BITS_DEFAULT,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int KW = 3 * COEF_BITS,
    localparam int CW = (KW > rgbc_pkg::FRAME_H_BITS) ? KW : rgbc_pkg::FRAME_H_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rgbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CW-1:0]                       cfg_wdata,
    input  logic                                accept,
    input  logic                                mode,
    input  rgbc_pkg::pixel_t                    pixel,
    input  logic                                move_b,
    output logic [KW-1:0]                       kernel_left,
    output logic [KW-1:0]                       kernel_mid,
    output logic [KW-1:0]                       kernel_right,
    output logic [AW-1:0]                       rd_addr,
    output logic                                valid_b,
    output rgbc_pkg::step_ctl_t                 ctl_b,
    output rgbc_pkg::pixel_t                    pix_b,
    output logic [AW-1:0]                       addr_b
);
    import rgbc_pkg::*;

    localparam int EW   = AW + 1;
    localparam int CMPW = (EW > FRAME_W_BITS) ? EW : FRAME_W_BITS;
    localparam logic [KW-1:0] KERNEL_MID_RESET = KW'(1) << COEF_BITS;

    logic [KW-1:0]           kl_reg, km_reg, kr_reg;
    logic [FRAME_W_BITS-1:0] fw_reg;
    logic [FRAME_H_BITS-1:0] fh_reg;

    logic [FRAME_H_BITS-1:0] r_reg, r_next;
    logic [AW-1:0]           c_reg, c_next;
    logic [FRAME_H_BITS-1:0] orow_reg, orow_next;
    logic [AW-1:0]           ocol_reg, ocol_next;

    logic      valid_b_reg, valid_b_next;
    step_ctl_t ctl_b_reg;
    pixel_t    pix_b_reg;
    logic [AW-1:0] addr_b_reg;

    logic [CMPW-1:0]         w_wide;
    logic [EW-1:0]           eff_w;
    logic [FRAME_H_BITS-1:0] eff_h;
    logic [AW-1:0]           c_eff;
    logic [EW-1:0]           c_inc, ocol_inc;
    logic                    in_frame, last_pos, geom_write;
    col_sel_t                left_pre;

    step_ctl_t               step_ctl;
    logic                    step_ignore, step_clear;
    logic [FRAME_H_BITS-1:0] step_r, step_orow;
    logic [AW-1:0]           step_c, step_ocol;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kl_reg <= '0;
            km_reg <= KERNEL_MID_RESET;
            kr_reg <= '0;
            fw_reg <= FRAME_WIDTH_RESET;
            fh_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KERNEL_LEFT:  kl_reg <= cfg_wdata[KW-1:0];
                REG_KERNEL_MID:   km_reg <= cfg_wdata[KW-1:0];
                REG_KERNEL_RIGHT: kr_reg <= cfg_wdata[KW-1:0];
                REG_FRAME_WIDTH:  fw_reg <= cfg_wdata[FRAME_W_BITS-1:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg_wdata[FRAME_H_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (fw_reg == '0) begin
            w_wide = CMPW'(1);
        end else if (CMPW'(fw_reg) > CMPW'(MAX_WIDTH)) begin
            w_wide = CMPW'(MAX_WIDTH);
        end else begin
            w_wide = CMPW'(fw_reg);
        end
    end

    assign eff_w      = EW'(w_wide);
    assign eff_h      = (fh_reg == '0) ? FRAME_H_BITS'(1) : fh_reg;
    assign c_eff      = ({1'b0, c_reg} >= eff_w) ? '0 : c_reg;
    assign c_inc      = {1'b0, c_eff} + EW'(1);
    assign ocol_inc   = {1'b0, ocol_reg} + EW'(1);
    assign in_frame   = r_reg < eff_h;
    assign last_pos   = (orow_reg == eff_h - FRAME_H_BITS'(1)) &&
                        ({1'b0, ocol_reg} == eff_w - EW'(1));
    assign left_pre   = (eff_w == EW'(1)) ? COL_NEW : COL_MID;
    assign geom_write = cfg_we &&
                        (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    // Decide what the beat does from the counters and the mode flag alone; pixel data follows later.
    always_comb begin
        step_ctl    = '0;
        step_ignore = 1'b0;
        step_clear  = 1'b0;
        if (in_frame && mode) begin
            step_ignore = 1'b1;
        end else if (!in_frame && last_pos) begin
            step_ctl.do_emit = 1'b1;
            step_ctl.last    = 1'b1;
            step_ctl.lc      = left_pre;
            step_ctl.cc      = COL_NEW;
            step_ctl.top_rep = (eff_h == FRAME_H_BITS'(1));
            step_clear       = 1'b1;
        end else begin
            step_ctl.do_shift = 1'b1;
            step_ctl.from_mem = !in_frame;
            if (c_eff == '0 && r_reg >= FRAME_H_BITS'(2)) begin
                step_ctl.do_emit = 1'b1;
                step_ctl.lc      = left_pre;
                step_ctl.cc      = COL_NEW;
                step_ctl.top_rep = (r_reg == FRAME_H_BITS'(2));
            end else if (c_eff != '0 && r_reg != '0) begin
                step_ctl.do_emit  = 1'b1;
                step_ctl.use_post = 1'b1;
                step_ctl.lc       = (c_eff == AW'(1)) ? COL_MID : COL_OLD;
                step_ctl.cc       = COL_MID;
                step_ctl.top_rep  = (r_reg == FRAME_H_BITS'(1));
            end
        end
    end

    always_comb begin
        step_r    = r_reg;
        step_c    = c_reg;
        step_orow = orow_reg;
        step_ocol = ocol_reg;
        if (step_clear) begin
            step_r    = '0;
            step_c    = '0;
            step_orow = '0;
            step_ocol = '0;
        end else if (!step_ignore) begin
            if (c_inc >= eff_w) begin
                step_c = '0;
                if (in_frame) begin
                    step_r = r_reg + FRAME_H_BITS'(1);
                end
            end else begin
                step_c = AW'(c_inc);
            end
            if (step_ctl.do_emit) begin
                if (ocol_inc >= eff_w) begin
                    step_ocol = '0;
                    step_orow = orow_reg + FRAME_H_BITS'(1);
                end else begin
                    step_ocol = AW'(ocol_inc);
                end
            end
        end
    end

    always_comb begin
        r_next       = r_reg;
        c_next       = c_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        valid_b_next = valid_b_reg;
        if (geom_write) begin
            r_next    = '0;
            c_next    = '0;
            orow_next = '0;
            ocol_next = '0;
        end else if (accept) begin
            r_next    = step_r;
            c_next    = step_c;
            orow_next = step_orow;
            ocol_next = step_ocol;
        end
        if (accept) begin
            valid_b_next = !step_ignore;
        end else if (move_b) begin
            valid_b_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg       <= '0;
            c_reg       <= '0;
            orow_reg    <= '0;
            ocol_reg    <= '0;
            valid_b_reg <= 1'b0;
        end else begin
            r_reg       <= r_next;
            c_reg       <= c_next;
            orow_reg    <= orow_next;
            ocol_reg    <= ocol_next;
            valid_b_reg <= valid_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctl_b_reg  <= step_ctl;
            pix_b_reg  <= pixel;
            addr_b_reg <= c_eff;
        end
    end

    assign kernel_left  = kl_reg;
    assign kernel_mid   = km_reg;
    assign kernel_right = kr_reg;
    assign rd_addr      = c_eff;
    assign valid_b      = valid_b_reg;
    assign ctl_b        = ctl_b_reg;
    assign pix_b        = pix_b_reg;
    assign addr_b       = addr_b_reg;

endmodule

// ===== design/rgbc_window.sv =====
module rgbc_window #(
    parameter int COEF_BITS = rgbc_pkg::COEF_BITS_DEFAULT,
    localparam int KW = 3 * COEF_BITS,
    localparam int PW = COEF_BITS + rgbc_pkg::CH_BITS + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 move_b,
    input  rgbc_pkg::step_ctl_t  ctl_b,
    input  rgbc_pkg::pixel_t     pix_b,
    input  rgbc_pkg::pixel_t     upper_q,
    input  rgbc_pkg::pixel_t     middle_q,
    input  logic [KW-1:0]        kernel_left,
    input  logic [KW-1:0]        kernel_mid,
    input  logic [KW-1:0]        kernel_right,
    input  logic                 move_c,
    output logic                 wr_en,
    output rgbc_pkg::pixel_t     wr_upper,
    output rgbc_pkg::pixel_t     wr_middle,
    output logic                 valid_c,
    output logic                 last_c,
    output logic signed [PW-1:0] prod [3][9]
);
    import rgbc_pkg::*;

    pixel_t win_reg [9];
    pixel_t win_post [9];
    pixel_t new_pix;

    logic signed [PW-1:0] prod_d   [3][9];
    logic signed [PW-1:0] prod_reg [3][9];
    logic                 last_c_reg;
    logic                 valid_c_reg, valid_c_next;

    // Window entry index is column * 3 + row, column 0 oldest, row 0 upper.
    assign new_pix = ctl_b.from_mem ? middle_q : pix_b;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            win_post[i] = win_reg[i + 3];
        end
        win_post[6] = upper_q;
        win_post[7] = middle_q;
        win_post[8] = new_pix;
    end

    assign wr_en     = move_b && ctl_b.do_shift;
    assign wr_upper  = middle_q;
    assign wr_middle = new_pix;

    always_comb begin
        logic [KW-1:0]               kreg;
        col_sel_t                    col;
        logic [1:0]                  row;
        logic [3:0]                  idx;
        pixel_t                      px;
        logic signed [COEF_BITS-1:0] cf;
        chan_t                       chv;
        for (int h = 0; h < 3; h++) begin
            if (h == 0) begin
                kreg = kernel_left;
                col  = ctl_b.lc;
            end else if (h == 1) begin
                kreg = kernel_mid;
                col  = ctl_b.cc;
            end else begin
                kreg = kernel_right;
                col  = COL_NEW;
            end
            for (int v = 0; v < 3; v++) begin
                row = (v == 0 && ctl_b.top_rep) ? 2'd1 : 2'(v);
                idx = 4'(col) * 4'd3 + 4'(row);
                px  = ctl_b.use_post ? win_post[idx] : win_reg[idx];
                cf  = kreg[v*COEF_BITS +: COEF_BITS];
                for (int ch = 0; ch < 3; ch++) begin
                    chv = px[ch*CH_BITS +: CH_BITS];
                    prod_d[ch][h*3 + v] = PW'($signed({1'b0, chv})) * PW'(cf);
                end
            end
        end
    end

    always_comb begin
        valid_c_next = valid_c_reg;
        if (move_b && ctl_b.do_emit) begin
            valid_c_next = 1'b1;
        end else if (move_c) begin
            valid_c_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
            valid_c_reg <= 1'b0;
        end else begin
            if (move_b && ctl_b.do_shift) begin
                win_reg <= win_post;
            end
            valid_c_reg <= valid_c_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (move_b && ctl_b.do_emit) begin
            prod_reg   <= prod_d;
            last_c_reg <= ctl_b.last;
        end
    end

    assign valid_c = valid_c_reg;
    assign last_c  = last_c_reg;
    assign prod    = prod_reg;

endmodule

// ===== design/rgbc_sum.sv =====
module rgbc_sum #(
    parameter int COEF_BITS = rgbc_pkg::COEF_BITS_DEFAULT,
    localparam int PW = COEF_BITS + rgbc_pkg::CH_BITS + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 move_c,
    input  logic signed [PW-1:0] prod [3][9],
    input  logic                 last_c,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output rgbc_pkg::pixel_t     m_tdata,
    output logic                 m_tlast
);
    import rgbc_pkg::*;

    localparam int SW = PW + 4;

    pixel_t tdata_next;
    pixel_t tdata_reg;
    logic   tlast_reg;
    logic   valid_o_reg, valid_o_next;

    // Each channel sum is clipped to the 8-bit pixel range.
    always_comb begin
        logic signed [SW-1:0] acc;
        for (int ch = 0; ch < 3; ch++) begin
            acc = '0;
            for (int k = 0; k < 9; k++) begin
                acc = acc + SW'(prod[ch][k]);
            end
            if (acc[SW-1]) begin
                tdata_next[ch*CH_BITS +: CH_BITS] = '0;
            end else if (acc > SW'(255)) begin
                tdata_next[ch*CH_BITS +: CH_BITS] = '1;
            end else begin
                tdata_next[ch*CH_BITS +: CH_BITS] = acc[CH_BITS-1:0];
            end
        end
    end

    always_comb begin
        valid_o_next = valid_o_reg;
        if (move_c) begin
            valid_o_next = 1'b1;
        end else if (m_tready) begin
            valid_o_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_o_reg <= 1'b0;
        end else begin
            valid_o_reg <= valid_o_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (move_c) begin
            tdata_reg <= tdata_next;
            tlast_reg <= last_c;
        end
    end

    assign m_tvalid = valid_o_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

endmodule

// ===== design/rgb_conv3x3_filter.sv =====
// Channel   Direction  Content
// s_        in         tdata = red, green, blue (8 bits each); tuser = in-frame skip flag
// m_        out        tdata = red, green, blue (8 bits each); tlast = last pixel of frame
// cfg_      in         write strobe, register index, write data
//
// One beat is taken per clock while s_tready is high; a beat passes the control stage,
// the window and multiply stage and the sum stage, each registered, and a result
// trails the beat that causes it by one row plus one pixel of the stream.
// Synchronous active-low reset clears counters, window and valid flags and restores
// the register defaults; the line stores are not cleared and need no clearing pass.
// A stalled output holds its beat while empty stages behind it keep filling.
module rgb_conv3x3_filter #(
    parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEFAULT,
    parameter int COEF_BITS = rgbc_pkg::COEF_BITS_DEFAULT,
    localparam int CW = (3 * COEF_BITS > rgbc_pkg::FRAME_H_BITS) ?
                        3 * COEF_BITS : rgbc_pkg::FRAME_H_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  rgbc_pkg::pixel_t                 s_tdata,   // red, green, blue
    input  logic                             s_tuser,   // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output rgbc_pkg::pixel_t                 m_tdata,   // red, green, blue
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [rgbc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CW-1:0]                    cfg_wdata
);
    import rgbc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int KW = 3 * COEF_BITS;
    localparam int PW = COEF_BITS + CH_BITS + 1;

    logic          accept, move_b, move_c, can_c, can_o;
    logic [KW-1:0] kernel_left, kernel_mid, kernel_right;
    logic [AW-1:0] rd_addr, addr_b;
    logic          valid_b, valid_c, last_c, wr_en;
    step_ctl_t     ctl_b;
    pixel_t        pix_b, upper_q, middle_q, wr_upper, wr_middle;
    logic signed [PW-1:0] prod [3][9];

    assign can_o    = !m_tvalid || m_tready;
    assign move_c   = valid_c && can_o;
    assign can_c    = !valid_c || move_c;
    assign move_b   = valid_b && (!ctl_b.do_emit || can_c);
    assign s_tready = !valid_b || move_b;
    assign accept   = s_tvalid && s_tready;

    rgbc_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .COEF_BITS (COEF_BITS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .accept       (accept),
        .mode         (s_tuser),
        .pixel        (s_tdata),
        .move_b       (move_b),
        .kernel_left  (kernel_left),
        .kernel_mid   (kernel_mid),
        .kernel_right (kernel_right),
        .rd_addr      (rd_addr),
        .valid_b      (valid_b),
        .ctl_b        (ctl_b),
        .pix_b        (pix_b),
        .addr_b       (addr_b)
    );

    rgbc_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (addr_b),
        .wr_data (wr_upper),
        .rd_data (upper_q)
    );

    rgbc_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (addr_b),
        .wr_data (wr_middle),
        .rd_data (middle_q)
    );

    rgbc_window #(
        .COEF_BITS (COEF_BITS)
    ) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .move_b       (move_b),
        .ctl_b        (ctl_b),
        .pix_b        (pix_b),
        .upper_q      (upper_q),
        .middle_q     (middle_q),
        .kernel_left  (kernel_left),
        .kernel_mid   (kernel_mid),
        .kernel_right (kernel_right),
        .move_c       (move_c),
        .wr_en        (wr_en),
        .wr_upper     (wr_upper),
        .wr_middle    (wr_middle),
        .valid_c      (valid_c),
        .last_c       (last_c),
        .prod         (prod)
    );

    rgbc_sum #(
        .COEF_BITS (COEF_BITS)
    ) u_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .move_c   (move_c),
        .prod     (prod),
        .last_c   (last_c),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
